@@ sv/rrm_pkg.sv @@
// Types and constants shared by the row run midpoint merger.
// Depends on nothing; compiled first.
`timescale 1ns / 1ps

package rrm_pkg;

    localparam int POINT_X_W = 12;
    localparam int ROW_W     = 10;
    localparam int LIMIT_W   = 12;

    typedef enum logic {
        RRM_OP_POINT = 1'b0,
        RRM_OP_FLUSH = 1'b1
    } rrm_op_t;

    typedef logic [LIMIT_W-1:0] rrm_limit_t;

    typedef struct packed {
        rrm_op_t                operation;
        logic [POINT_X_W-1:0]   point_x;
        logic [ROW_W-1:0]       point_row;
    } rrm_point_t;

    typedef struct packed {
        logic [POINT_X_W-1:0]   centre_x;
        logic [ROW_W-1:0]       centre_row;
    } rrm_centre_t;

endpackage

@@ sv/rrm_stream_if.sv @@
// Valid/ready channel with a typed payload.
// Payload types come from rrm_pkg at the place of instantiation.
`timescale 1ns / 1ps

interface rrm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rrm_row_store.sv @@
// Per-row run memory: one read port, one write port, registered read data.
// Runs a clearing pass over all rows after reset. Uses no package items.
`timescale 1ns / 1ps

module rrm_row_store #(
    parameter int ROWS   = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              busy
);

    logic [DATA_W-1:0] mem [ROWS];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Steer the write port to the clearing sweep while it runs
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    // Advance the clearing sweep, one row per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == ADDR_W'(ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Memory array with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

@@ sv/row_run_midpoint_merger.sv @@
// Top level of the row run midpoint merger: input stage, run update, result register.
// Depends on rrm_pkg, rrm_stream_if and rrm_row_store.
//
//  channel   dir   payload                               transfer when
//  points    in    operation, point_x, point_row         valid && ready
//  centres   out   centre_x, centre_row                  valid && ready
//  cfg       in    merge_limit (12 bits)                 valid && ready (ready always high)
//
// One item per cycle while centres are taken; the update stage feeds the result register.
// The rate is set by the single read-modify-write of the row memory per item;
// a same-row item in the next cycle takes the freshly written entry by forwarding.
// After reset a clearing pass over all ROWS rows runs before the first point is taken.
// A stalled result holds the update stage, which in turn holds points.ready low.
`timescale 1ns / 1ps

module row_run_midpoint_merger #(
    parameter int ROWS        = 1024,
    parameter int COLUMN_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    rrm_stream_if.sink    points,
    rrm_stream_if.source  centres,
    rrm_stream_if.sink    cfg
);
    import rrm_pkg::*;

    localparam int ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RCMP_W  = 17;
    localparam int XEXT_W  = 16;
    localparam int CMP_W   = (COLUMN_BITS > LIMIT_W) ? COLUMN_BITS : LIMIT_W;
    localparam int DATA_W  = 1 + 2 * COLUMN_BITS;

    typedef logic [COLUMN_BITS-1:0] col_t;

    // Configuration
    rrm_limit_t limit_reg;

    // Update stage
    logic               s1_valid_reg;
    rrm_op_t            s1_op_reg;
    col_t               s1_x_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_in_range_reg;

    // Forward of the last written entry
    logic               fwd_valid_reg;
    logic [ROW_W-1:0]   fwd_row_reg;
    logic [DATA_W-1:0]  fwd_data_reg;

    // Result register
    logic               out_valid_reg;
    rrm_centre_t        out_data_reg;

    logic               store_busy;
    logic [DATA_W-1:0]  rd_data;
    logic               stage_go;
    logic               accept;
    logic               process;
    logic [RCMP_W-1:0]  in_row_ext;
    logic [ADDR_W-1:0]  in_addr;
    logic [RCMP_W-1:0]  s1_row_ext;
    logic [ADDR_W-1:0]  s1_addr;
    logic [XEXT_W-1:0]  in_x_ext;
    logic [DATA_W-1:0]  entry;
    logic               run_open;
    col_t               run_start;
    col_t               run_end;
    logic               adjacent;
    col_t               span;
    logic               over_limit;
    col_t               end_eff;
    col_t               centre;
    logic               emit;
    logic [DATA_W-1:0]  new_entry;
    logic [XEXT_W-1:0]  centre_ext;

    rrm_row_store #(
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (process && s1_in_range_reg),
        .wr_addr (s1_addr),
        .wr_data (new_entry),
        .busy    (store_busy)
    );

    // Handshakes
    assign stage_go      = !out_valid_reg || centres.ready;
    assign points.ready  = !store_busy && (!s1_valid_reg || stage_go);
    assign accept        = points.valid && points.ready;
    assign process       = s1_valid_reg && stage_go;
    assign cfg.ready     = 1'b1;

    // Input row and column decode
    assign in_row_ext = RCMP_W'(points.data.point_row);
    assign in_addr    = in_row_ext[ADDR_W-1:0];
    assign in_x_ext   = XEXT_W'(points.data.point_x);
    assign s1_row_ext = RCMP_W'(s1_row_reg);
    assign s1_addr    = s1_row_ext[ADDR_W-1:0];

    // Pick the row entry, forwarding the last write when it went to the same row
    assign entry     = (fwd_valid_reg && (fwd_row_reg == s1_row_reg)) ? fwd_data_reg : rd_data;
    assign run_open  = entry[DATA_W-1];
    assign run_start = entry[2*COLUMN_BITS-1:COLUMN_BITS];
    assign run_end   = entry[COLUMN_BITS-1:0];

    // Extend test, span check and floor midpoint
    assign adjacent   = run_open &&
                        (({1'b0, run_end} + 1'b1) == {1'b0, s1_x_reg});
    assign span       = s1_x_reg - run_start;
    assign over_limit = CMP_W'(span) > CMP_W'(limit_reg);
    assign end_eff    = ((s1_op_reg == RRM_OP_POINT) && adjacent) ? s1_x_reg : run_end;
    assign centre     = run_start + ((end_eff - run_start) >> 1);
    assign centre_ext = XEXT_W'(centre);

    // New entry and result decision
    always_comb
    begin
        unique case (s1_op_reg)
            RRM_OP_FLUSH:
            begin
                emit      = run_open;
                new_entry = {1'b0, run_start, run_end};
            end
            RRM_OP_POINT:
            begin
                if (adjacent)
                begin
                    emit      = over_limit;
                    new_entry = {!over_limit, run_start, s1_x_reg};
                end
                else
                begin
                    emit      = run_open;
                    new_entry = {1'b1, s1_x_reg, s1_x_reg};
                end
            end
            default:
            begin
                emit      = 1'b0;
                new_entry = entry;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            limit_reg <= cfg.data;
        end
    end

    // Update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (process && s1_in_range_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (stage_go)
            begin
                out_valid_reg <= process && s1_in_range_reg && emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= points.data.operation;
            s1_x_reg        <= in_x_ext[COLUMN_BITS-1:0];
            s1_row_reg      <= points.data.point_row;
            s1_in_range_reg <= in_row_ext < RCMP_W'(ROWS);
        end
        if (process && s1_in_range_reg)
        begin
            fwd_row_reg  <= s1_row_reg;
            fwd_data_reg <= new_entry;
        end
        if (process)
        begin
            out_data_reg.centre_x   <= centre_ext[POINT_X_W-1:0];
            out_data_reg.centre_row <= s1_row_reg;
        end
    end

    assign centres.valid = out_valid_reg;
    assign centres.data  = out_data_reg;

endmodule

@@ verif/row_run_midpoint_merger_tb.sv @@
// Self-checking testbench for row_run_midpoint_merger: a directed table, then random
// phases at several merge limits, with every centre checked against a predictor or table.
// Depends on rrm_pkg, rrm_stream_if and the merger RTL.
`timescale 1ns / 1ps

module row_run_midpoint_merger_tb;

    import rrm_pkg::*;

    localparam int ROWS             = 1024;
    localparam int DIRECTED_ROWS    = 28;
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 290;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD        = 400;
    localparam int WATCHDOG_LIMIT   = 6000;
    localparam int MAX_ERROR_LINES  = 40;

    typedef enum bit { STEP_ITEM, STEP_LIMIT } step_kind_t;
    typedef enum bit [1:0] { CHK_MODEL, CHK_NONE, CHK_CENTRE } chk_kind_t;
    typedef enum bit [1:0] {
        STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY
    } stall_mode_t;

    // One directed row: an item or a limit write (limit value rides in col)
    typedef struct {
        step_kind_t         kind;
        rrm_op_t            op;
        logic [POINT_X_W-1:0] col;
        logic [ROW_W-1:0]   row;
        chk_kind_t          chk;
        logic [POINT_X_W-1:0] cx;
        logic [ROW_W-1:0]   crow;
    } step_t;

    typedef struct {
        chk_kind_t   kind;
        rrm_centre_t centre;
    } check_note_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rrm_stream_if #(.T(rrm_point_t))  points_ch ();
    rrm_stream_if #(.T(rrm_centre_t)) centres_ch ();
    rrm_stream_if #(.T(rrm_limit_t))  cfg_ch ();

    row_run_midpoint_merger #(
        .ROWS        (ROWS),
        .COLUMN_BITS (POINT_X_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points_ch),
        .centres (centres_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state: open run per row and the active limit
    logic [POINT_X_W-1:0] run_lo   [ROWS];
    logic [POINT_X_W-1:0] run_hi   [ROWS];
    bit                   run_live [ROWS];
    rrm_limit_t           merge_limit_q = '0;

    rrm_centre_t centre_q [$];
    check_note_t check_q [$];
    int          error_count = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;

    step_t directed_steps [0:DIRECTED_ROWS-1] = '{
        // reset limit 0: any extension closes the run at once
        '{STEP_ITEM,  RRM_OP_POINT, 12'd5,    10'd0,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd6,    10'd0,    CHK_CENTRE, 12'd5,    10'd0},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd0,    10'd0,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd4095, 10'd1023, CHK_NONE,   12'd0,    10'd0},
        // column zero after the last column: no wrap, so it closes the run
        '{STEP_ITEM,  RRM_OP_POINT, 12'd0,    10'd1023, CHK_CENTRE, 12'd4095, 10'd1023},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd4095, 10'd1023, CHK_CENTRE, 12'd0,    10'd1023},
        '{STEP_LIMIT, RRM_OP_POINT, 12'd4095, 10'd0,    CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd0,    10'd512,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd1,    10'd512,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd2,    10'd512,  CHK_NONE,   12'd0,    10'd0},
        // same column, further left, then a gap: each closes and reopens
        '{STEP_ITEM,  RRM_OP_POINT, 12'd2,    10'd512,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd1,    10'd512,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd5,    10'd512,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd4094, 10'd7,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd4095, 10'd7,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd0,    10'd7,    CHK_CENTRE, 12'd4094, 10'd7},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd0,    10'd7,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd4095, 10'd100,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_LIMIT, RRM_OP_POINT, 12'd2,    10'd0,    CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd100,  10'd300,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd101,  10'd300,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd102,  10'd300,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd103,  10'd300,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd104,  10'd300,  CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd0,    10'd300,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_FLUSH, 12'd0,    10'd512,  CHK_MODEL,  12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd4095, 10'd0,    CHK_NONE,   12'd0,    10'd0},
        '{STEP_ITEM,  RRM_OP_POINT, 12'd4095, 10'd0,    CHK_MODEL,  12'd0,    10'd0}
    };

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_ERROR_LINES)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Close the open run of a row and return its floor midpoint
    function automatic rrm_centre_t close_run(input int unsigned row);
        rrm_centre_t c;
        logic [POINT_X_W-1:0] span;
        span = run_hi[row] - run_lo[row];
        c.centre_x = run_lo[row] + (span >> 1);
        c.centre_row = ROW_W'(row);
        run_live[row] = 1'b0;
        return c;
    endfunction

    // Apply one item to the run table; returns 1 when a centre comes out
    function automatic bit merge_point(input rrm_point_t p, output rrm_centre_t c);
        int unsigned row;
        bit emitted;
        row = p.point_row;
        c = '0;
        if (p.operation == RRM_OP_FLUSH)
        begin
            if (!run_live[row])
                return 1'b0;
            c = close_run(row);
            return 1'b1;
        end
        // extend only when the point sits one column right of the run end
        if (run_live[row] && ({1'b0, run_hi[row]} + 1'b1 == {1'b0, p.point_x}))
        begin
            run_hi[row] = p.point_x;
            if (run_hi[row] - run_lo[row] > merge_limit_q)
            begin
                c = close_run(row);
                return 1'b1;
            end
            return 1'b0;
        end
        emitted = run_live[row];
        if (emitted)
            c = close_run(row);
        run_lo[row] = p.point_x;
        run_hi[row] = p.point_x;
        run_live[row] = 1'b1;
        return emitted;
    endfunction

    // Track transfers: check centres, follow limit writes, predict for points
    always @(posedge clk)
    begin : merge_check
        rrm_centre_t got;
        rrm_centre_t want;
        rrm_centre_t calc;
        check_note_t note;
        bit made;
        if (rst_n)
        begin
            if (centres_ch.valid && centres_ch.ready)
            begin
                got = centres_ch.data;
                if (centre_q.size() == 0)
                    report_mismatch($sformatf("unexpected centre x=%0d row=%0d",
                                              got.centre_x, got.centre_row));
                else
                begin
                    want = centre_q.pop_front();
                    if (got.centre_x !== want.centre_x)
                        report_mismatch($sformatf("centre_x %0d, want %0d (row %0d)",
                                                  got.centre_x, want.centre_x,
                                                  want.centre_row));
                    if (got.centre_row !== want.centre_row)
                        report_mismatch($sformatf("centre_row %0d, want %0d",
                                                  got.centre_row, want.centre_row));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                merge_limit_q = cfg_ch.data;
            if (points_ch.valid && points_ch.ready)
            begin
                note = check_q.pop_front();
                made = merge_point(points_ch.data, calc);
                case (note.kind)
                    CHK_MODEL:  if (made) centre_q = {centre_q, calc};
                    CHK_CENTRE: centre_q = {centre_q, note.centre};
                    default:    ;
                endcase
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin : stall_watch
        int idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((points_ch.valid && points_ch.ready) || (centres_ch.valid && centres_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side: stall patterns that are picked and switched at random,
    // plus one long hold-off on request
    initial
    begin : centre_sink
        stall_mode_t mode;
        int mode_left;
        int tick;
        mode = STALL_NONE;
        mode_left = 0;
        tick = 0;
        centres_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                centres_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            tick++;
            case (mode)
                STALL_NONE:     centres_ch.ready <= 1'b1;
                STALL_RANDOM:   centres_ch.ready <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: centres_ch.ready <= (tick % 3 != 0);
                default:        centres_ch.ready <= ($urandom_range(0, 9) < 4);
            endcase
            @(posedge clk);
        end
    end

    // Offer one point, idling between bursts; returns at the transfer edge
    task automatic offer_point(input rrm_point_t p, input chk_kind_t kind,
                               input rrm_centre_t c);
        int gap;
        check_note_t note;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                points_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        note.kind = kind;
        note.centre = c;
        check_q = {check_q, note};
        points_ch.valid <= 1'b1;
        points_ch.data <= p;
        do
            @(posedge clk);
        while (!points_ch.ready);
    endtask

    // Hold points until every centre has come out, then let the pipe empty
    task automatic drain_centres();
        points_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (centre_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input rrm_limit_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Main stimulus
    initial
    begin : stimulus
        rrm_point_t p;
        rrm_centre_t c;
        logic [ROW_W-1:0] row_pool [4];
        logic [POINT_X_W-1:0] seq_col [ROWS];
        rrm_limit_t phase_limit [RANDOM_PHASES];
        logic [ROW_W-1:0] r;
        int pick;

        points_ch.valid = 1'b0;
        points_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            run_live[i] = 1'b0;
            seq_col[i] = '0;
        end

        // Hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_steps[i].kind == STEP_LIMIT)
            begin
                drain_centres();
                write_limit(rrm_limit_t'(directed_steps[i].col));
            end
            else
            begin
                p.operation = directed_steps[i].op;
                p.point_x = directed_steps[i].col;
                p.point_row = directed_steps[i].row;
                c.centre_x = directed_steps[i].cx;
                c.centre_row = directed_steps[i].crow;
                offer_point(p, directed_steps[i].chk, c);
            end
        end

        // Random phases: limit 1, 0, max, short, anything, 3
        phase_limit[0] = 12'd1;
        phase_limit[1] = 12'd0;
        phase_limit[2] = 12'd4095;
        phase_limit[3] = rrm_limit_t'($urandom_range(2, 6));
        phase_limit[4] = rrm_limit_t'($urandom_range(0, 4095));
        phase_limit[5] = 12'd3;
        c = '0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_centres();
            write_limit(phase_limit[ph]);
            for (int k = 0; k < 4; k++)
                row_pool[k] = ROW_W'($urandom_range(0, ROWS - 1));
            if (ph == 0)
            begin
                row_pool[0] = '0;
                row_pool[1] = ROW_W'(ROWS - 1);
            end
            // let results back up until points stall
            if (ph == 2)
                hold_off_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                r = row_pool[$urandom_range(0, 3)];
                if (pick < 8)
                begin
                    // noise: any field value
                    p.operation = rrm_op_t'($urandom_range(0, 1));
                    p.point_x = POINT_X_W'($urandom);
                    p.point_row = ROW_W'($urandom);
                end
                else if (pick < 16)
                begin
                    p.operation = RRM_OP_FLUSH;
                    p.point_x = POINT_X_W'($urandom);
                    p.point_row = r;
                end
                else
                begin
                    // mostly grow the row's run, sometimes break it
                    p.operation = RRM_OP_POINT;
                    p.point_row = r;
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        p.point_x = seq_col[r] + 1'b1;
                    else if (pick < 85)
                        p.point_x = seq_col[r];
                    else if (pick < 92)
                        p.point_x = POINT_X_W'(4095 - $urandom_range(0, 4));
                    else
                        p.point_x = POINT_X_W'($urandom);
                    seq_col[r] = p.point_x;
                end
                offer_point(p, CHK_MODEL, c);
            end
        end

        drain_centres();
        if (error_count == 0 && centre_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rrm_pkg.sv
sv/rrm_stream_if.sv
sv/rrm_row_store.sv
sv/row_run_midpoint_merger.sv
verif/row_run_midpoint_merger_tb.sv
